// ----- hdl/fmbq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fmbq_pkg
// Types and constants shared by the front/middle/back queue and its cells.
// ----------------------------------------------------------------------------
package fmbq_pkg;

    localparam int CapacityDefault = 64;
    // index width that covers the largest supported capacity (4096)
    localparam int PosW            = 12;
    localparam int WordW           = 32;
    localparam int FillW           = 7;

    localparam logic [2:0] REQ_PUSH_FRONT  = 3'd0;
    localparam logic [2:0] REQ_PUSH_MIDDLE = 3'd1;
    localparam logic [2:0] REQ_PUSH_BACK   = 3'd2;
    localparam logic [2:0] REQ_POP_FRONT   = 3'd3;
    localparam logic [2:0] REQ_POP_MIDDLE  = 3'd4;
    localparam logic [2:0] REQ_POP_BACK    = 3'd5;

    typedef struct packed {
        logic [2:0]              req_type;
        logic signed [WordW-1:0] push_value;
    } t_req;

    typedef struct packed {
        logic signed [WordW-1:0] pop_value;
        logic                    was_empty;
        logic                    was_full;
        logic [FillW-1:0]        fill_count;
    } t_result;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [PosW-1:0]   pos;
        logic [WordW-1:0]  value;
    } t_cell_ctrl;

endpackage
`default_nettype wire

// ----- hdl/fmbq_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fmbq_cell
// One queue slot: holds a word, takes the neighbor's word when the queue opens
// or closes a gap at or below its place, and offers its word when removed.
// ----------------------------------------------------------------------------
module fmbq_cell #(
    parameter int Idx = 0
) (
    input  wire logic                           i_clk,
    input  wire fmbq_pkg::t_cell_ctrl           i_ctrl,
    input  wire logic [fmbq_pkg::WordW-1:0]     i_left,
    input  wire logic [fmbq_pkg::WordW-1:0]     i_right,
    output logic      [fmbq_pkg::WordW-1:0]     o_word,
    output logic      [fmbq_pkg::WordW-1:0]     o_pop_word
);

    localparam logic [fmbq_pkg::PosW-1:0] MyPos = fmbq_pkg::PosW'(Idx);

    logic [fmbq_pkg::WordW-1:0] r_word;
    logic [fmbq_pkg::WordW-1:0] n_word;
    logic                       at_pos;
    logic                       above_pos;

    assign at_pos    = (i_ctrl.pos == MyPos);
    assign above_pos = (MyPos > i_ctrl.pos);

    always_comb begin
        n_word = r_word;
        case (i_ctrl.op)
            fmbq_pkg::CELL_INSERT: begin
                if (at_pos) begin
                    n_word = i_ctrl.value;
                end else if (above_pos) begin
                    n_word = i_left;
                end
            end
            fmbq_pkg::CELL_REMOVE: begin
                if (at_pos || above_pos) begin
                    n_word = i_right;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word     = r_word;
    // and-or select: only the removed cell drives a non-zero word
    assign o_pop_word = (i_ctrl.op == fmbq_pkg::CELL_REMOVE && at_pos) ? r_word : '0;

endmodule
`default_nettype wire

// ----- hdl/front_middle_back_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// front_middle_back_queue
// Ordered queue of signed words with push and pop at front, middle and back.
// ----------------------------------------------------------------------------
// A request is taken on start while busy is low and its result appears on
// o_result with o_valid high for one cycle, in the cycle after the request;
// the receiver cannot stall, so it must take every result when it is shown.
// One request is taken every clock while busy is low: the queue is a row of
// CAPACITY cells, and those at and above the insert/remove point shift in the
// same cycle, and the removed word is picked off the row by an and-or select.
// busy is high only while reset is held and until the first clock after it.
// A middle push inserts at floor(n/2), a middle pop removes floor((n-1)/2);
// fill_count shows the fill level after the request, modulo 128.
// ----------------------------------------------------------------------------
module front_middle_back_queue #(
    parameter int CAPACITY = fmbq_pkg::CapacityDefault
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire fmbq_pkg::t_req    i_req,
    output logic                   o_valid,
    output fmbq_pkg::t_result      o_result
);

    localparam int CntW = $clog2(CAPACITY + 1);

    logic [fmbq_pkg::WordW-1:0] words     [CAPACITY];
    logic [fmbq_pkg::WordW-1:0] pop_words [CAPACITY];

    logic                  r_busy;
    logic                  r_valid;
    fmbq_pkg::t_result     r_result;
    fmbq_pkg::t_result     n_result;
    logic [CntW-1:0]       r_count;
    logic [CntW-1:0]       n_count;
    fmbq_pkg::t_cell_ctrl  ctrl;
    logic                  accept;
    logic                  is_full;
    logic                  is_empty;
    logic [fmbq_pkg::WordW-1:0] popped;

    assign accept   = start && !r_busy;
    assign is_full  = (r_count == CntW'(CAPACITY));
    assign is_empty = (r_count == '0);

    always_comb begin
        ctrl.op    = fmbq_pkg::CELL_HOLD;
        ctrl.pos   = '0;
        ctrl.value = i_req.push_value;
        n_count    = r_count;
        case (i_req.req_type)
            fmbq_pkg::REQ_PUSH_FRONT: begin
                ctrl.pos = '0;
                if (!is_full) begin
                    ctrl.op = fmbq_pkg::CELL_INSERT;
                    n_count = r_count + 1'b1;
                end
            end
            fmbq_pkg::REQ_PUSH_MIDDLE: begin
                ctrl.pos = fmbq_pkg::PosW'(r_count >> 1);
                if (!is_full) begin
                    ctrl.op = fmbq_pkg::CELL_INSERT;
                    n_count = r_count + 1'b1;
                end
            end
            fmbq_pkg::REQ_PUSH_BACK: begin
                ctrl.pos = fmbq_pkg::PosW'(r_count);
                if (!is_full) begin
                    ctrl.op = fmbq_pkg::CELL_INSERT;
                    n_count = r_count + 1'b1;
                end
            end
            fmbq_pkg::REQ_POP_FRONT: begin
                ctrl.pos = '0;
                if (!is_empty) begin
                    ctrl.op = fmbq_pkg::CELL_REMOVE;
                    n_count = r_count - 1'b1;
                end
            end
            fmbq_pkg::REQ_POP_MIDDLE: begin
                ctrl.pos = fmbq_pkg::PosW'((r_count - 1'b1) >> 1);
                if (!is_empty) begin
                    ctrl.op = fmbq_pkg::CELL_REMOVE;
                    n_count = r_count - 1'b1;
                end
            end
            fmbq_pkg::REQ_POP_BACK: begin
                ctrl.pos = fmbq_pkg::PosW'(r_count - 1'b1);
                if (!is_empty) begin
                    ctrl.op = fmbq_pkg::CELL_REMOVE;
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                ctrl.op = fmbq_pkg::CELL_HOLD;
            end
        endcase
        // cells move only on an accepted transaction
        if (!accept) begin
            ctrl.op = fmbq_pkg::CELL_HOLD;
            n_count = r_count;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            fmbq_cell #(
                .Idx (gi)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (ctrl),
                .i_left     (words[(gi == 0) ? 0 : gi - 1]),
                .i_right    (words[(gi == CAPACITY - 1) ? gi : gi + 1]),
                .o_word     (words[gi]),
                .o_pop_word (pop_words[gi])
            );
        end
    endgenerate

    always_comb begin
        popped = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            popped = popped | pop_words[k];
        end
    end

    always_comb begin
        n_result            = '0;
        n_result.fill_count = fmbq_pkg::FillW'(n_count);
        if (i_req.req_type inside {fmbq_pkg::REQ_PUSH_FRONT, fmbq_pkg::REQ_PUSH_MIDDLE,
                                   fmbq_pkg::REQ_PUSH_BACK}) begin
            n_result.was_full = is_full;
        end else if (i_req.req_type inside {fmbq_pkg::REQ_POP_FRONT,
                                            fmbq_pkg::REQ_POP_MIDDLE,
                                            fmbq_pkg::REQ_POP_BACK}) begin
            n_result.was_empty = is_empty;
            n_result.pop_value = is_empty ? '1 : $signed(popped);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            r_busy  <= 1'b0;
            r_valid <= accept;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign busy     = r_busy;
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire

// ----- hdl/fmbq_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fmbq_checker
// Port-level checks for the front/middle/back queue, bound to the top level.
// ----------------------------------------------------------------------------
module fmbq_checker (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_busy,
    input  wire logic              i_valid,
    input  wire fmbq_pkg::t_result i_result
);

    logic accept;
    assign accept = i_start && !i_busy;

    // every transaction gives exactly one result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> i_valid)
        else $error("no result after accepted transaction");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !i_valid)
        else $error("result without transaction");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_result.was_empty) |->
            (i_result.pop_value == -32'sd1 && i_result.fill_count == '0))
        else $error("empty pop result malformed");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> !(i_result.was_empty && i_result.was_full))
        else $error("empty and full flagged together");

    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_result.was_full) |-> (i_result.pop_value == '0))
        else $error("dropped push returned a word");

endmodule

bind front_middle_back_queue fmbq_checker u_fmbq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (start),
    .i_busy   (busy),
    .i_valid  (o_valid),
    .i_result (o_result)
);
`default_nettype wire

// ----- tb/front_middle_back_queue_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// front_middle_back_queue_tb
// Self-checking bench for the front/middle/back queue. A short table of
// directed requests (empty pops, unused request codes, extreme words and
// middle-position shuffles) is followed by random requests in fill and drain
// bursts that push the queue to full and back to empty. Every transaction is
// run through a queue model in the bench, and each result strobe is compared
// field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module front_middle_back_queue_tb;

    localparam int CAPACITY = fmbq_pkg::CapacityDefault;

    // request codes that the block does not decode
    localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

    localparam logic signed [fmbq_pkg::WordW-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [fmbq_pkg::WordW-1:0] WORD_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic [2:0]                        op;
        logic signed [fmbq_pkg::WordW-1:0] value;
        bit                                typed;
        logic signed [fmbq_pkg::WordW-1:0] pop_value;
        bit                                was_empty;
        bit                                was_full;
        logic [fmbq_pkg::FillW-1:0]        fill_count;
    } t_dir_row;

    // typed rows carry the expected result; the rest go through the model
    localparam int DirRows = 21;
    t_dir_row dir_rows [DirRows] = '{
        '{fmbq_pkg::REQ_POP_FRONT,   32'sd0,         1'b1, -32'sd1,  1'b1, 1'b0, 7'd0},
        '{fmbq_pkg::REQ_POP_MIDDLE,  32'sd0,         1'b1, -32'sd1,  1'b1, 1'b0, 7'd0},
        '{fmbq_pkg::REQ_POP_BACK,    -32'sd1,        1'b1, -32'sd1,  1'b1, 1'b0, 7'd0},
        '{REQ_UNUSED_6,              32'sd0,         1'b1, 32'sd0,   1'b0, 1'b0, 7'd0},
        '{REQ_UNUSED_7,              -32'sd1,        1'b1, 32'sd0,   1'b0, 1'b0, 7'd0},
        '{fmbq_pkg::REQ_PUSH_BACK,   WORD_MAX,       1'b1, 32'sd0,   1'b0, 1'b0, 7'd1},
        '{fmbq_pkg::REQ_PUSH_FRONT,  WORD_MIN,       1'b1, 32'sd0,   1'b0, 1'b0, 7'd2},
        '{fmbq_pkg::REQ_PUSH_MIDDLE, 32'sd0,         1'b1, 32'sd0,   1'b0, 1'b0, 7'd3},
        '{fmbq_pkg::REQ_PUSH_MIDDLE, -32'sd1,        1'b1, 32'sd0,   1'b0, 1'b0, 7'd4},
        '{fmbq_pkg::REQ_PUSH_BACK,   32'sd1,         1'b0, 32'sd0,   1'b0, 1'b0, 7'd0},
        '{fmbq_pkg::REQ_POP_MIDDLE,  32'sd0,         1'b0, 32'sd0,   1'b0, 1'b0, 7'd0},
        '{fmbq_pkg::REQ_POP_FRONT,   32'sd0,         1'b1, WORD_MIN, 1'b0, 1'b0, 7'd3},
        '{fmbq_pkg::REQ_POP_BACK,    WORD_MAX,       1'b0, 32'sd0,   1'b0, 1'b0, 7'd0},
        '{fmbq_pkg::REQ_PUSH_FRONT,  32'sh5555_5555, 1'b0, 32'sd0,   1'b0, 1'b0, 7'd0},
        '{fmbq_pkg::REQ_PUSH_MIDDLE, 32'shaaaa_aaaa, 1'b0, 32'sd0,   1'b0, 1'b0, 7'd0},
        '{REQ_UNUSED_6,              32'sd123,       1'b0, 32'sd0,   1'b0, 1'b0, 7'd0},
        '{fmbq_pkg::REQ_POP_MIDDLE,  32'sd0,         1'b0, 32'sd0,   1'b0, 1'b0, 7'd0},
        '{fmbq_pkg::REQ_POP_MIDDLE,  32'sd0,         1'b0, 32'sd0,   1'b0, 1'b0, 7'd0},
        '{fmbq_pkg::REQ_POP_MIDDLE,  32'sd0,         1'b0, 32'sd0,   1'b0, 1'b0, 7'd0},
        '{fmbq_pkg::REQ_POP_MIDDLE,  32'sd0,         1'b1, WORD_MAX, 1'b0, 1'b0, 7'd0},
        '{fmbq_pkg::REQ_POP_BACK,    32'sd0,         1'b1, -32'sd1,  1'b1, 1'b0, 7'd0}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    fmbq_pkg::t_req    i_req;
    logic              o_valid;
    fmbq_pkg::t_result o_result;

    // expected result of the request being offered, when typed in the table
    bit                pinned_on;
    fmbq_pkg::t_result pinned_result;

    logic signed [fmbq_pkg::WordW-1:0] queue_model [$];
    fmbq_pkg::t_result                 pending_results [$];

    int err_count;
    int accepted_count;
    int full_drops;
    int empty_pops;
    int peak_fill;
    int idle_pct;

    front_middle_back_queue #(
        .CAPACITY (CAPACITY)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    // apply one request to the queue model and return its result
    function automatic fmbq_pkg::t_result step_queue_model(fmbq_pkg::t_req req);
        fmbq_pkg::t_result res;
        int                n;
        res = '0;
        n   = queue_model.size();
        case (req.req_type)
            fmbq_pkg::REQ_PUSH_FRONT, fmbq_pkg::REQ_PUSH_MIDDLE,
            fmbq_pkg::REQ_PUSH_BACK: begin
                if (n >= CAPACITY) begin
                    res.was_full = 1'b1;
                end else if (req.req_type == fmbq_pkg::REQ_PUSH_FRONT) begin
                    queue_model.insert(0, req.push_value);
                end else if (req.req_type == fmbq_pkg::REQ_PUSH_MIDDLE) begin
                    queue_model.insert(n / 2, req.push_value);
                end else begin
                    queue_model.insert(n, req.push_value);
                end
            end
            fmbq_pkg::REQ_POP_FRONT, fmbq_pkg::REQ_POP_MIDDLE,
            fmbq_pkg::REQ_POP_BACK: begin
                if (n == 0) begin
                    res.was_empty = 1'b1;
                    res.pop_value = '1;
                end else if (req.req_type == fmbq_pkg::REQ_POP_FRONT) begin
                    res.pop_value = queue_model[0];
                    queue_model.delete(0);
                end else if (req.req_type == fmbq_pkg::REQ_POP_MIDDLE) begin
                    res.pop_value = queue_model[(n - 1) / 2];
                    queue_model.delete((n - 1) / 2);
                end else begin
                    res.pop_value = queue_model[n - 1];
                    queue_model.delete(n - 1);
                end
            end
            default: ;
        endcase
        res.fill_count = fmbq_pkg::FillW'(queue_model.size());
        return res;
    endfunction

    always @(posedge i_clk) begin : result_check
        fmbq_pkg::t_result want;
        fmbq_pkg::t_result modeled;
        if (i_rst_n) begin
            if (o_valid) begin
                if (pending_results.size() == 0) begin
                    $error("result with no transaction waiting");
                    err_count++;
                end else begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (o_result.pop_value !== want.pop_value) begin
                        $error("pop_value: expected %0d, actual %0d",
                               want.pop_value, o_result.pop_value);
                        err_count++;
                    end
                    if (o_result.was_empty !== want.was_empty) begin
                        $error("was_empty: expected %0b, actual %0b",
                               want.was_empty, o_result.was_empty);
                        err_count++;
                    end
                    if (o_result.was_full !== want.was_full) begin
                        $error("was_full: expected %0b, actual %0b",
                               want.was_full, o_result.was_full);
                        err_count++;
                    end
                    if (o_result.fill_count !== want.fill_count) begin
                        $error("fill_count: expected %0d, actual %0d",
                               want.fill_count, o_result.fill_count);
                        err_count++;
                    end
                end
            end
            if (start && !busy) begin
                modeled = step_queue_model(i_req);
                pending_results.insert(pending_results.size(),
                                       pinned_on ? pinned_result : modeled);
                accepted_count++;
                if (modeled.was_full) full_drops++;
                if (modeled.was_empty) empty_pops++;
                if (queue_model.size() > peak_fill) peak_fill = queue_model.size();
            end
        end
    end

    // offer one request, idling first at the current rate, and wait for it to be taken
    task automatic send_req(input fmbq_pkg::t_req req, input bit typed,
                            input fmbq_pkg::t_result typed_res);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_req         <= req;
        pinned_on     <= typed;
        pinned_result <= typed_res;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    function automatic fmbq_pkg::t_req random_req(int push_pct);
        fmbq_pkg::t_req req;
        req.push_value = $urandom();
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
                0: req.push_value = WORD_MIN;
                1: req.push_value = WORD_MAX;
                2: req.push_value = '0;
                default: req.push_value = '1;
            endcase
        end
        if ($urandom_range(99) < 3) begin
            req.req_type = $urandom_range(1) ? REQ_UNUSED_6 : REQ_UNUSED_7;
        end else if ($urandom_range(99) < push_pct) begin
            req.req_type = 3'($urandom_range(fmbq_pkg::REQ_PUSH_BACK,
                                             fmbq_pkg::REQ_PUSH_FRONT));
        end else begin
            req.req_type = 3'($urandom_range(fmbq_pkg::REQ_POP_BACK,
                                             fmbq_pkg::REQ_POP_FRONT));
        end
        return req;
    endfunction

    initial begin : stimulus
        fmbq_pkg::t_result typed_res;
        fmbq_pkg::t_req    req;
        int                phase_idle [4];
        int                burst_push [4];
        int                waited;
        phase_idle     = '{0, 50, 0, 32};
        burst_push     = '{90, 90, 10, 10};
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_req          = '0;
        pinned_on      = 1'b0;
        pinned_result  = '0;
        err_count      = 0;
        accepted_count = 0;
        full_drops     = 0;
        empty_pops     = 0;
        peak_fill      = 0;
        idle_pct       = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            req.req_type          = dir_rows[k].op;
            req.push_value        = dir_rows[k].value;
            typed_res.pop_value   = dir_rows[k].pop_value;
            typed_res.was_empty   = dir_rows[k].was_empty;
            typed_res.was_full    = dir_rows[k].was_full;
            typed_res.fill_count  = dir_rows[k].fill_count;
            send_req(req, dir_rows[k].typed, typed_res);
        end

        // fill bursts run into the full limit, drain bursts run dry
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = phase_idle[ph];
            for (int b = 0; b < 4; b++) begin
                for (int k = 0; k < 65; k++) begin
                    send_req(random_req(burst_push[b]), 1'b0, '0);
                end
            end
        end
        start <= 1'b0;

        waited = 0;
        while (pending_results.size() != 0 && waited < 100) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            err_count++;
        end

        $display("%0d transactions checked, peak fill %0d of %0d",
                 accepted_count, peak_fill, CAPACITY);
        $display("%0d pushes dropped on a full queue, %0d pops from an empty queue",
                 full_drops, empty_pops);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire

// ----- sim.f -----
hdl/fmbq_pkg.sv
hdl/fmbq_cell.sv
hdl/front_middle_back_queue.sv
hdl/fmbq_checker.sv
tb/front_middle_back_queue_tb.sv
